FILE: rtl/mfcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI file chunk parser package
// Types, tag constants and the result record shared by the parser modules.
// ----------------------------------------------------------------------------
package mfcp_pkg;

	localparam logic [31:0] TAG_HEADER  = 32'h4D54_6864; // "MThd"
	localparam logic [31:0] TAG_TRACK   = 32'h4D54_726B; // "MTrk"
	localparam logic [31:0] HEADER_LEN  = 32'd6;
	localparam logic [2:0]  FIELD_BYTES = 3'd4;

	typedef enum logic [1:0] {
		PH_TYPE   = 2'd0,
		PH_LENGTH = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CK_HEADER  = 2'd0,
		CK_TRACK   = 2'd1,
		CK_UNKNOWN = 2'd2
	} chunk_kind_t;

	typedef enum logic [1:0] {
		RK_CHUNK  = 2'd0,
		RK_FIELDS = 2'd1,
		RK_BODY   = 2'd2
	} result_kind_t;

	typedef struct packed {
		result_kind_t result_kind;
		chunk_kind_t  chunk_type;
		logic [31:0]  chunk_length;
		logic         header_bad;
		logic [15:0]  file_format;
		logic [15:0]  track_count;
		logic [15:0]  time_division;
		logic [7:0]   body_byte;
		logic         body_last;
	} mfcp_result_t;

endpackage : mfcp_pkg
`default_nettype wire

FILE: rtl/mfcp_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI file byte channel
// Valid/ready channel that moves one raw file byte per beat.
// ----------------------------------------------------------------------------
interface mfcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface : mfcp_byte_if
`default_nettype wire

FILE: rtl/mfcp_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI file result channel
// Valid/ready channel that moves one parser result record per beat.
// ----------------------------------------------------------------------------
interface mfcp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [1:0]  chunk_type;
	logic [31:0] chunk_length;
	logic        header_bad;
	logic [15:0] file_format;
	logic [15:0] track_count;
	logic [15:0] time_division;
	logic [7:0]  body_byte;
	logic        body_last;

	modport source (
		output valid, output result_kind, output chunk_type, output chunk_length,
		output header_bad, output file_format, output track_count,
		output time_division, output body_byte, output body_last,
		input ready
	);
	modport sink (
		input valid, input result_kind, input chunk_type, input chunk_length,
		input header_bad, input file_format, input track_count,
		input time_division, input body_byte, input body_last,
		output ready
	);
endinterface : mfcp_result_if
`default_nettype wire

FILE: rtl/mfcp_chunk_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI file chunk state machine
// Walks type, length and body phases of each chunk, one byte per step.
// ----------------------------------------------------------------------------
module mfcp_chunk_fsm (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            data_byte,
	output mfcp_pkg::mfcp_result_t     result,
	output logic                       result_valid
);

	mfcp_pkg::phase_t      phase_q, phase_d;
	mfcp_pkg::chunk_kind_t kind_q, kind_d;
	logic [2:0]            index_q, index_d;
	logic [31:0]           type_q, type_d;
	logic [31:0]           length_q, length_d;
	logic [31:0]           left_q, left_d;
	logic [47:0]           hshift_q, hshift_d;
	logic                  emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mfcp_pkg::PH_TYPE;
			kind_q   <= mfcp_pkg::CK_HEADER;
			index_q  <= '0;
			type_q   <= '0;
			length_q <= '0;
			left_q   <= '0;
			hshift_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			index_q  <= index_d;
			type_q   <= type_d;
			length_q <= length_d;
			left_q   <= left_d;
			hshift_q <= hshift_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		index_d  = index_q;
		type_d   = type_q;
		length_d = length_q;
		left_d   = left_q;
		hshift_d = hshift_q;
		emit     = 1'b0;
		result   = '0;

		unique case (phase_q)
			mfcp_pkg::PH_LENGTH: begin
				length_d = {length_q[23:0], data_byte};
				index_d  = index_q + 3'd1;
				if (index_d >= mfcp_pkg::FIELD_BYTES) begin
					emit               = 1'b1;
					result.result_kind = mfcp_pkg::RK_CHUNK;
					result.header_bad  = (kind_q == mfcp_pkg::CK_HEADER) &&
						(length_d != mfcp_pkg::HEADER_LEN);
					left_d   = length_d;
					hshift_d = '0;
					if (length_d == '0) begin
						phase_d = mfcp_pkg::PH_TYPE;
						index_d = '0;
						type_d  = '0;
					end else begin
						phase_d = mfcp_pkg::PH_BODY;
					end
				end
			end
			mfcp_pkg::PH_BODY: begin
				left_d = left_q - 32'd1;
				if (kind_q == mfcp_pkg::CK_HEADER) begin
					if (length_q == mfcp_pkg::HEADER_LEN) begin
						hshift_d = {hshift_q[39:0], data_byte};
						if (left_d == '0) begin
							emit                 = 1'b1;
							result.result_kind   = mfcp_pkg::RK_FIELDS;
							result.file_format   = hshift_d[47:32];
							result.track_count   = hshift_d[31:16];
							result.time_division = hshift_d[15:0];
						end
					end
				end else begin
					emit               = 1'b1;
					result.result_kind = mfcp_pkg::RK_BODY;
					result.body_byte   = data_byte;
					result.body_last   = (left_d == '0);
				end
				if (left_d == '0) begin
					phase_d = mfcp_pkg::PH_TYPE;
					index_d = '0;
					type_d  = '0;
				end
			end
			default: begin
				// Type bytes; the unused phase code is handled the same way.
				phase_d = mfcp_pkg::PH_TYPE;
				type_d  = {type_q[23:0], data_byte};
				index_d = index_q + 3'd1;
				if (index_d >= mfcp_pkg::FIELD_BYTES) begin
					if (type_d == mfcp_pkg::TAG_HEADER) begin
						kind_d = mfcp_pkg::CK_HEADER;
					end else if (type_d == mfcp_pkg::TAG_TRACK) begin
						kind_d = mfcp_pkg::CK_TRACK;
					end else begin
						kind_d = mfcp_pkg::CK_UNKNOWN;
					end
					length_d = '0;
					index_d  = '0;
					phase_d  = mfcp_pkg::PH_LENGTH;
				end
			end
		endcase

		result.chunk_type   = kind_d;
		result.chunk_length = length_d;
		result_valid        = step && emit;
	end

endmodule : mfcp_chunk_fsm
`default_nettype wire

FILE: rtl/midi_file_chunk_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI file chunk parser core
// Splits a Standard MIDI File byte stream into chunk, header and body results.
// ----------------------------------------------------------------------------
// Usage:
// The bytes channel takes the file one byte per beat, starting at a chunk
// boundary. The results channel gives at most one record per byte: a chunk
// record after the fourth length byte, a header record after the sixth byte of
// a well-formed MThd body, and one body record per byte of track and unknown
// chunks, with body_last on the final byte.
// A byte is first captured in an input register; the chunk state machine then
// updates its state and writes any result into the output register. A result
// therefore appears once its byte has passed both registers, and one byte is
// taken every cycle while the receiver keeps up.
// When the receiver stalls, the pending result stays in the output register
// and the input register still holds one more byte; ready drops only when
// both are full. Ready is never low while the output register is empty.
// Reset clears all control state; the parser then expects a chunk type tag.
// ----------------------------------------------------------------------------
module midi_file_chunk_parser_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mfcp_byte_if.sink       bytes,
	mfcp_result_if.source   results
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	logic                   step;
	logic                   out_valid_q;
	mfcp_pkg::mfcp_result_t res_q;
	mfcp_pkg::mfcp_result_t fsm_result;
	logic                   fsm_valid;

	// The state machine moves on when the output register can take a result.
	assign advance     = !out_valid_q || results.ready;
	assign step        = valid_s1 && advance;
	assign bytes.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	mfcp_chunk_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (byte_s1),
		.result       (fsm_result),
		.result_valid (fsm_valid)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fsm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fsm_valid) begin
			res_q <= fsm_result;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.result_kind   = res_q.result_kind;
	assign results.chunk_type    = res_q.chunk_type;
	assign results.chunk_length  = res_q.chunk_length;
	assign results.header_bad    = res_q.header_bad;
	assign results.file_format   = res_q.file_format;
	assign results.track_count   = res_q.track_count;
	assign results.time_division = res_q.time_division;
	assign results.body_byte     = res_q.body_byte;
	assign results.body_last     = res_q.body_last;

`ifndef SYNTHESIS
	// Body records only come from track and unknown chunks.
	a_body_not_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.result_kind == mfcp_pkg::RK_BODY) |->
		(res_q.chunk_type != mfcp_pkg::CK_HEADER))
		else $error("body record carries a header chunk type");

	// Header field records only follow a header of length six.
	a_fields_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.result_kind == mfcp_pkg::RK_FIELDS) |->
		(res_q.chunk_length == mfcp_pkg::HEADER_LEN &&
		 res_q.chunk_type == mfcp_pkg::CK_HEADER))
		else $error("header fields reported for a malformed header");

	// A bad-header flag only rides on a chunk record of a header chunk.
	a_bad_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.header_bad) |->
		(res_q.result_kind == mfcp_pkg::RK_CHUNK &&
		 res_q.chunk_type == mfcp_pkg::CK_HEADER))
		else $error("header_bad set on a wrong record");

	// An empty output register never holds back the input side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> bytes.ready)
		else $error("input stalled while output register is empty");
`endif

endmodule : midi_file_chunk_parser_core
`default_nettype wire

FILE: tb/mfcp_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI file chunk parser record checker
// Watches the byte and result channels, predicts the result records from the
// accepted bytes and compares each result beat field by field.
// ----------------------------------------------------------------------------
module mfcp_record_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	mfcp_byte_if      bytes,
	mfcp_result_if    results,
	output int        errors,
	output int        owed
);

	// Parser state as the predictor sees it.
	mfcp_pkg::phase_t      phase;
	logic [2:0]            field_idx;
	logic [31:0]           tag_shift;
	logic [31:0]           chunk_len;
	logic [31:0]           body_left;
	mfcp_pkg::chunk_kind_t kind;
	logic [47:0]           hdr_shift;

	mfcp_pkg::mfcp_result_t pending_records[$];
	int                     fail_total = 0;

	function automatic mfcp_pkg::mfcp_result_t blank_record(mfcp_pkg::result_kind_t rk);
		mfcp_pkg::mfcp_result_t rec = '0;
		rec.result_kind  = rk;
		rec.chunk_type   = kind;
		rec.chunk_length = chunk_len;
		return rec;
	endfunction

	task automatic restart_chunk();
		phase     = mfcp_pkg::PH_TYPE;
		field_idx = '0;
		tag_shift = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		mfcp_pkg::mfcp_result_t rec;
		case (phase)
			mfcp_pkg::PH_LENGTH: begin
				chunk_len = {chunk_len[23:0], b};
				field_idx = field_idx + 3'd1;
				if (field_idx >= mfcp_pkg::FIELD_BYTES) begin
					rec = blank_record(mfcp_pkg::RK_CHUNK);
					rec.header_bad = (kind == mfcp_pkg::CK_HEADER) &&
						(chunk_len != mfcp_pkg::HEADER_LEN);
					pending_records.push_back(rec);
					body_left = chunk_len;
					hdr_shift = '0;
					if (body_left == 0)
						restart_chunk();
					else
						phase = mfcp_pkg::PH_BODY;
				end
			end
			mfcp_pkg::PH_BODY: begin
				body_left = body_left - 32'd1;
				if (kind == mfcp_pkg::CK_HEADER) begin
					// The body of a header of the wrong size is swallowed without any record.
					if (chunk_len == mfcp_pkg::HEADER_LEN) begin
						hdr_shift = {hdr_shift[39:0], b};
						if (body_left == 0) begin
							rec = blank_record(mfcp_pkg::RK_FIELDS);
							rec.file_format   = hdr_shift[47:32];
							rec.track_count   = hdr_shift[31:16];
							rec.time_division = hdr_shift[15:0];
							pending_records.push_back(rec);
						end
					end
				end else begin
					rec = blank_record(mfcp_pkg::RK_BODY);
					rec.body_byte = b;
					rec.body_last = (body_left == 0);
					pending_records.push_back(rec);
				end
				if (body_left == 0)
					restart_chunk();
			end
			default: begin
				phase     = mfcp_pkg::PH_TYPE;
				tag_shift = {tag_shift[23:0], b};
				field_idx = field_idx + 3'd1;
				if (field_idx >= mfcp_pkg::FIELD_BYTES) begin
					if (tag_shift == mfcp_pkg::TAG_HEADER)
						kind = mfcp_pkg::CK_HEADER;
					else if (tag_shift == mfcp_pkg::TAG_TRACK)
						kind = mfcp_pkg::CK_TRACK;
					else
						kind = mfcp_pkg::CK_UNKNOWN;
					chunk_len = '0;
					field_idx = '0;
					phase     = mfcp_pkg::PH_LENGTH;
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mfcp_pkg::mfcp_result_t want;
		if (!arst_n) begin
			restart_chunk();
			chunk_len = '0;
			body_left = '0;
			kind      = mfcp_pkg::CK_HEADER;
			hdr_shift = '0;
			pending_records.delete();
		end else begin
			// Results come from earlier bytes, so the compare goes first.
			if (results.valid && results.ready) begin
				if (pending_records.size() == 0) begin
					$error("result beat arrived with no record expected");
					fail_total++;
				end else begin
					want = pending_records.pop_front();
					compare_field("result_kind", want.result_kind, results.result_kind);
					compare_field("chunk_type", want.chunk_type, results.chunk_type);
					compare_field("chunk_length", want.chunk_length, results.chunk_length);
					compare_field("header_bad", want.header_bad, results.header_bad);
					compare_field("file_format", want.file_format, results.file_format);
					compare_field("track_count", want.track_count, results.track_count);
					compare_field("time_division", want.time_division,
						results.time_division);
					compare_field("body_byte", want.body_byte, results.body_byte);
					compare_field("body_last", want.body_last, results.body_last);
				end
			end
			if (bytes.valid && bytes.ready)
				parse_byte(bytes.data_byte);
		end
		errors <= fail_total;
		owed   <= pending_records.size();
	end

endmodule : mfcp_record_checker

FILE: tb/midi_file_chunk_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI file chunk parser core test
// Feeds the parser a stream of header, track and unknown chunks, well formed
// and broken, under varying source gaps and sink stalls; a side checker
// predicts every result record and compares it with what the parser gives.
// ----------------------------------------------------------------------------
module midi_file_chunk_parser_core_test;

	// Number of bytes in the randomized part of the stream.
	localparam int RANDOM_BYTES = 700;
	// Length of the one long sink hold-off, in clock cycles.
	localparam int HOLD_CYCLES  = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Idle percentages for the source and the sink; the stimulus process
	// changes them from one phase of the run to the next.
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	// Raised by the stimulus to ask the sink for one long hold-off.
	logic hold_req       = 1'b0;
	int   bytes_sent     = 0;

	int mismatch_count;
	int records_owed;

	mfcp_byte_if   bytes();
	mfcp_result_if results();

	midi_file_chunk_parser_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.results (results)
	);

	mfcp_record_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.results (results),
		.errors  (mismatch_count),
		.owed    (records_owed)
	);

	always #10 clk = ~clk;

	// Offers one byte, possibly after a few idle cycles, and returns at the
	// edge where the beat is taken. Valid is left high so that back-to-back
	// bytes go out without a bubble.
	task automatic put_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			bytes.valid <= 1'b0;
			@(posedge clk);
		end
		bytes.valid     <= 1'b1;
		bytes.data_byte <= value;
		@(posedge clk);
		while (!bytes.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Big-endian, as the file format stores tags and lengths.
	task automatic put_word(input logic [31:0] word);
		for (int i = 3; i >= 0; i--)
			put_byte(word[i*8 +: 8]);
	endtask

	// A chunk whose body is random; the body count may be shorter than the
	// length when the stream is meant to end inside a chunk.
	task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len,
			input int body_bytes);
		put_word(tag);
		put_word(len);
		repeat (body_bytes)
			put_byte($urandom_range(255));
	endtask

	// The source goes quiet until every predicted record has come out.
	task automatic drain();
		bytes.valid <= 1'b0;
		@(posedge clk);
		while (records_owed != 0)
			@(posedge clk);
	endtask

	// Body lengths stay short so that the run sees many chunk boundaries;
	// empty bodies are common on purpose.
	function automatic logic [31:0] pick_body_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return 32'd0;
		if (roll < 90)
			return 32'($urandom_range(1, 24));
		return 32'($urandom_range(25, 60));
	endfunction

	// Sink side: random stalls at the current percentage, except for the
	// single long hold-off, which is counted here cycle by cycle.
	initial begin : sink_side
		int n;
		bit hold_taken;
		hold_taken = 1'b0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				results.ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				results.ready <= 1'b0;
				for (n = 1; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				results.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : stimulus
		int          start;
		int          mode;
		int          last_mode;
		int          roll;
		bit          hold_done;
		logic [31:0] tag;
		logic [31:0] len;

		bytes.valid     <= 1'b0;
		bytes.data_byte <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: a well-formed header whose words hold all-ones,
		// all-zeros and mixed bytes, then a one-byte track, so that the single
		// body byte is also the last one.
		put_word(mfcp_pkg::TAG_HEADER);
		put_word(mfcp_pkg::HEADER_LEN);
		put_word(32'hFFFF_0000);
		put_byte(8'h80);
		put_byte(8'h7F);
		put_chunk(mfcp_pkg::TAG_TRACK, 32'd1, 1);
		drain();

		// Random part, in four phases of idling: none, source gaps, sink
		// stalls, then light gaps on both sides. At every phase change the
		// source pauses until the parser has delivered everything it owes.
		start     = bytes_sent;
		last_mode = 0;
		hold_done = 1'b0;
		while (bytes_sent < start + RANDOM_BYTES) begin
			mode = (bytes_sent - start) * 4 / RANDOM_BYTES;
			if (mode != last_mode) begin
				drain();
				last_mode = mode;
				case (mode)
					1: begin
						send_idle_pct  = 45;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct  = 0;
						recv_stall_pct = 45;
					end
					default: begin
						send_idle_pct  = 10;
						recv_stall_pct = 10;
					end
				endcase
			end

			// Once, early on: the sink holds off for a long stretch while a
			// long track keeps coming, so the parser fills up and pushes back.
			if (!hold_done && bytes_sent >= start + 60) begin
				hold_done = 1'b1;
				hold_req <= 1'b1;
				put_chunk(mfcp_pkg::TAG_TRACK, 32'd48, 48);
				continue;
			end

			roll = $urandom_range(99);
			if (roll < 45) begin
				len = pick_body_len();
				put_chunk(mfcp_pkg::TAG_TRACK, len, len);
			end else if (roll < 65) begin
				// Mostly well-formed headers; the rest have a wrong length,
				// zero included, and their bodies are dropped silently.
				if ($urandom_range(9) < 7) begin
					put_chunk(mfcp_pkg::TAG_HEADER, mfcp_pkg::HEADER_LEN, 6);
				end else begin
					len = 32'($urandom_range(12));
					if (len == mfcp_pkg::HEADER_LEN)
						len = mfcp_pkg::HEADER_LEN + 32'd1;
					put_chunk(mfcp_pkg::TAG_HEADER, len, len);
				end
			end else if (roll < 85) begin
				len = pick_body_len();
				put_chunk($urandom, len, len);
			end else begin
				// Near misses: a known tag with one byte corrupted.
				tag = $urandom_range(1) ? mfcp_pkg::TAG_HEADER : mfcp_pkg::TAG_TRACK;
				tag = tag ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
				len = pick_body_len();
				put_chunk(tag, len, len);
			end
		end

		// The stream ends inside an unknown chunk of the largest length, so
		// every length bit is seen high and no last mark is due.
		drain();
		put_chunk(32'h0000_0000, 32'hFFFF_FFFF, 5);
		bytes.valid <= 1'b0;

		@(posedge clk);
		while (records_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && records_owed == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Far beyond the slowest legal run.
	initial begin : watchdog
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule : midi_file_chunk_parser_core_test

FILE: files.f
rtl/mfcp_pkg.sv
rtl/mfcp_byte_if.sv
rtl/mfcp_result_if.sv
rtl/mfcp_chunk_fsm.sv
rtl/midi_file_chunk_parser_core.sv
tb/mfcp_record_checker.sv
tb/midi_file_chunk_parser_core_test.sv
